// File: rtl/assert_macros.svh
// Assertion macros shared by the track event parser RTL.
// Every check samples on the rising edge of clk and sleeps while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds at a clock edge outside reset.
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// File: rtl/mtep_pkg.sv
// Package for the track event parser: transaction structs, event kinds, error codes.
// It depends on nothing else. The parser and the top level import it.
`timescale 1ns / 1ps
`default_nettype none

package mtep_pkg;

    // Longest delta time or length field, in bytes.
    localparam logic [2:0] VLQ_MAX_BYTES = 3'd4;

    typedef logic [3:0] kind_t;
    localparam kind_t KIND_NOTEOFF   = 4'd0;
    localparam kind_t KIND_NOTEON    = 4'd1;
    localparam kind_t KIND_POLYPRESS = 4'd2;
    localparam kind_t KIND_CTRL      = 4'd3;
    localparam kind_t KIND_PROGRAM   = 4'd4;
    localparam kind_t KIND_CHANPRESS = 4'd5;
    localparam kind_t KIND_BEND      = 4'd6;
    localparam kind_t KIND_META      = 4'd7;
    localparam kind_t KIND_SYSEX     = 4'd8;
    localparam kind_t KIND_NONE      = 4'd9;

    typedef logic [2:0] err_t;
    localparam err_t ERR_NONE        = 3'd0;
    localparam err_t ERR_META_LEN    = 3'd1;
    localparam err_t ERR_META_TYPE   = 3'd2;
    localparam err_t ERR_NO_RUNNING  = 3'd3;
    localparam err_t ERR_OVERLONG    = 3'd4;

    localparam logic [7:0] STATUS_SYSEX = 8'hF0;
    localparam logic [7:0] STATUS_META  = 8'hFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       track_start;
    } item_t;

    typedef struct packed {
        logic [27:0] event_delta;
        kind_t       event_kind;
        logic [3:0]  channel;
        logic [7:0]  param_a;
        logic [7:0]  param_b;
        logic        restated_status;
        logic [7:0]  meta_type;
        logic [23:0] meta_value;
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic        is_last;
        err_t        error_code;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/mtep_parser.sv
// Parser state and the per-byte decode of the track event stream.
// Depends on mtep_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module mtep_parser (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step,
    input  wire mtep_pkg::item_t item,
    output logic                 res_valid,
    output mtep_pkg::result_t    res
);
    import mtep_pkg::*;

    typedef enum logic [3:0] {
        PH_DELTA,
        PH_STATUS,
        PH_DATA1,
        PH_DATA2,
        PH_MTYPE,
        PH_MLEN,
        PH_MBODY,
        PH_MVALUE,
        PH_SKIP,
        PH_SXLEN,
        PH_SXBODY
    } phase_t;

    typedef enum logic [1:0] {
        MC_VALUE,
        MC_FIXED,
        MC_FREE,
        MC_UNKNOWN
    } meta_class_t;

    typedef struct packed {
        phase_t      phase;
        logic [7:0]  running_stat;
        logic [7:0]  cur_status;
        logic        restated_flag;
        logic [27:0] delta_acc;
        logic [2:0]  vlq_count;
        logic [27:0] bytes_left;
        logic [7:0]  meta_kind;
        logic [23:0] value_acc;
        logic [7:0]  first_data;
    } state_t;

    function automatic meta_class_t meta_class(input logic [7:0] t);
        priority if (t == 8'h00 || t == 8'h20 || t == 8'h21 || t == 8'h51)
            return MC_VALUE;
        else if (t >= 8'h01 && t <= 8'h09)
            return MC_FREE;
        else if (t == 8'h7F)
            return MC_FREE;
        else if (t == 8'h2F || t == 8'h54 || t == 8'h58 || t == 8'h59)
            return MC_FIXED;
        else
            return MC_UNKNOWN;
    endfunction

    function automatic logic [2:0] meta_need(input logic [7:0] t);
        priority if (t == 8'h00 || t == 8'h59)
            return 3'd2;
        else if (t == 8'h20 || t == 8'h21)
            return 3'd1;
        else if (t == 8'h51)
            return 3'd3;
        else if (t == 8'h54)
            return 3'd5;
        else if (t == 8'h58)
            return 3'd4;
        else
            return 3'd0;
    endfunction

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_t      cur;
        logic [7:0]  b;
        logic [27:0] vacc;
        logic [27:0] vnew;
        logic [2:0]  cnt_new;
        logic        over_hi;
        logic        vlq_more;
        logic        vlq_over;
        logic [27:0] left_dec;
        logic [3:0]  hi;
        meta_class_t cls;
        logic        do_finish;
        kind_t       kind;
        logic [7:0]  pa;
        logic [7:0]  pb;
        logic [23:0] mval;
        logic [7:0]  pbyte;
        logic        pvalid;
        logic        last;
        err_t        err;

        // A track start restarts the parser before this byte is taken.
        cur = state_reg;
        if (item.track_start)
        begin
            cur       = '0;
            cur.phase = PH_DELTA;
        end

        b        = item.data_byte;
        vacc     = (cur.phase == PH_MLEN || cur.phase == PH_SXLEN) ? cur.bytes_left
                                                                  : cur.delta_acc;
        over_hi  = |vacc[27:21];
        vnew     = {vacc[20:0], b[6:0]};
        cnt_new  = cur.vlq_count + 3'd1;
        vlq_over = over_hi || (b[7] && cnt_new >= VLQ_MAX_BYTES);
        vlq_more = !vlq_over && b[7];
        left_dec = cur.bytes_left - 28'd1;
        hi       = 4'h0;
        cls      = meta_class(cur.meta_kind);

        state_next = cur;
        do_finish  = 1'b0;
        res_valid  = 1'b0;
        kind       = KIND_NONE;
        pa         = '0;
        pb         = '0;
        mval       = '0;
        pbyte      = '0;
        pvalid     = 1'b0;
        last       = 1'b1;
        err        = ERR_NONE;

        unique case (cur.phase)
            PH_STATUS:
            begin
                if (!b[7])
                begin
                    if (cur.running_stat == 8'h00)
                    begin
                        res_valid = 1'b1;
                        err       = ERR_NO_RUNNING;
                        do_finish = 1'b1;
                    end
                    else
                    begin
                        // Running status: this byte is already the first data byte.
                        state_next.cur_status    = cur.running_stat;
                        state_next.restated_flag = 1'b0;
                        state_next.first_data    = b;
                        hi = cur.running_stat[7:4];
                        if (hi == 4'hC || hi == 4'hD)
                        begin
                            res_valid = 1'b1;
                            kind      = hi - 4'h8;
                            pa        = b;
                            do_finish = 1'b1;
                        end
                        else
                            state_next.phase = PH_DATA2;
                    end
                end
                else
                begin
                    state_next.restated_flag = (cur.running_stat == b);
                    state_next.cur_status    = b;
                    state_next.vlq_count     = '0;
                    state_next.bytes_left    = '0;
                    if (b < STATUS_SYSEX)
                    begin
                        state_next.running_stat = b;
                        state_next.phase        = PH_DATA1;
                    end
                    else if (b == STATUS_META)
                        state_next.phase = PH_MTYPE;
                    else
                        state_next.phase = PH_SXLEN;
                end
            end

            PH_DATA1:
            begin
                state_next.first_data = b;
                hi = cur.cur_status[7:4];
                if (hi == 4'hC || hi == 4'hD)
                begin
                    res_valid = 1'b1;
                    kind      = hi - 4'h8;
                    pa        = b;
                    do_finish = 1'b1;
                end
                else
                    state_next.phase = PH_DATA2;
            end

            PH_DATA2:
            begin
                res_valid = 1'b1;
                kind      = cur.cur_status[7:4] - 4'h8;
                pa        = cur.first_data;
                pb        = b;
                do_finish = 1'b1;
            end

            PH_MTYPE:
            begin
                state_next.meta_kind  = b;
                state_next.vlq_count  = '0;
                state_next.bytes_left = '0;
                state_next.phase      = PH_MLEN;
            end

            PH_MLEN:
            begin
                kind = KIND_META;
                if (!over_hi)
                begin
                    state_next.bytes_left = vnew;
                    state_next.vlq_count  = cnt_new;
                end
                if (vlq_over)
                begin
                    res_valid = 1'b1;
                    err       = ERR_OVERLONG;
                    do_finish = 1'b1;
                end
                else if (!vlq_more)
                begin
                    state_next.vlq_count = '0;
                    if (cls == MC_UNKNOWN
                        || (cls != MC_FREE && vnew != {25'd0, meta_need(cur.meta_kind)}))
                    begin
                        // Skip the payload and flag it on its last byte, or at once if it is empty.
                        if (vnew == 28'd0)
                        begin
                            res_valid = 1'b1;
                            err       = (cls == MC_UNKNOWN) ? ERR_META_TYPE : ERR_META_LEN;
                            do_finish = 1'b1;
                        end
                        else
                            state_next.phase = PH_SKIP;
                    end
                    else if (vnew == 28'd0)
                    begin
                        res_valid = 1'b1;
                        do_finish = 1'b1;
                    end
                    else
                    begin
                        state_next.value_acc = '0;
                        state_next.phase     = (cls == MC_VALUE) ? PH_MVALUE : PH_MBODY;
                    end
                end
            end

            PH_MVALUE:
            begin
                kind                  = KIND_META;
                state_next.value_acc  = {cur.value_acc[15:0], b};
                state_next.bytes_left = left_dec;
                mval                  = {cur.value_acc[15:0], b};
                if (left_dec == 28'd0)
                begin
                    res_valid = 1'b1;
                    do_finish = 1'b1;
                end
            end

            PH_MBODY, PH_SXBODY:
            begin
                kind                  = (cur.phase == PH_MBODY) ? KIND_META : KIND_SYSEX;
                state_next.bytes_left = left_dec;
                res_valid             = 1'b1;
                pbyte                 = b;
                pvalid                = 1'b1;
                last                  = (left_dec == 28'd0);
                do_finish             = (left_dec == 28'd0);
            end

            PH_SKIP:
            begin
                kind                  = KIND_META;
                state_next.bytes_left = left_dec;
                err                   = (cls == MC_UNKNOWN) ? ERR_META_TYPE : ERR_META_LEN;
                if (left_dec == 28'd0)
                begin
                    res_valid = 1'b1;
                    do_finish = 1'b1;
                end
            end

            PH_SXLEN:
            begin
                kind = KIND_SYSEX;
                if (!over_hi)
                begin
                    state_next.bytes_left = vnew;
                    state_next.vlq_count  = cnt_new;
                end
                if (vlq_over)
                begin
                    res_valid = 1'b1;
                    err       = ERR_OVERLONG;
                    do_finish = 1'b1;
                end
                else if (!vlq_more)
                begin
                    state_next.vlq_count = '0;
                    if (cur.cur_status == STATUS_SYSEX)
                    begin
                        // Prepend the F0 that the file format strips.
                        res_valid = 1'b1;
                        pbyte     = STATUS_SYSEX;
                        pvalid    = 1'b1;
                        last      = (vnew == 28'd0);
                        do_finish = (vnew == 28'd0);
                        if (vnew != 28'd0)
                            state_next.phase = PH_SXBODY;
                    end
                    else if (vnew == 28'd0)
                    begin
                        res_valid = 1'b1;
                        do_finish = 1'b1;
                    end
                    else
                        state_next.phase = PH_SXBODY;
                end
            end

            default:
            begin
                if (!over_hi)
                begin
                    state_next.delta_acc = vnew;
                    state_next.vlq_count = cnt_new;
                end
                state_next.phase = PH_DELTA;
                if (vlq_over)
                begin
                    res_valid = 1'b1;
                    err       = ERR_OVERLONG;
                    do_finish = 1'b1;
                end
                else if (!vlq_more)
                begin
                    state_next.vlq_count = '0;
                    state_next.phase     = PH_STATUS;
                end
            end
        endcase

        res.event_delta     = state_next.delta_acc;
        res.event_kind      = kind;
        res.channel         = (kind <= KIND_BEND) ? state_next.cur_status[3:0] : 4'h0;
        res.param_a         = pa;
        res.param_b         = pb;
        res.restated_status = (kind <= KIND_BEND) ? state_next.restated_flag : 1'b0;
        res.meta_type       = (kind == KIND_META) ? state_next.meta_kind : 8'h00;
        res.meta_value      = mval;
        res.payload_byte    = pbyte;
        res.payload_valid   = pvalid;
        res.is_last         = last;
        res.error_code      = err;

        // End of event: back to the delta time with cleared counters.
        if (do_finish)
        begin
            state_next.phase      = PH_DELTA;
            state_next.delta_acc  = '0;
            state_next.vlq_count  = '0;
            state_next.bytes_left = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= '0;
            state_reg.phase <= PH_DELTA;
        end
        else if (step)
            state_reg <= state_next;
    end

    `ASSERT_CLK(a_delta_no_length, state_reg.phase == PH_DELTA |-> state_reg.bytes_left == 28'd0,
        "length counter not cleared while reading a delta time")
    `ASSERT_NEVER(a_vlq_count_range, state_reg.vlq_count >= VLQ_MAX_BYTES,
        "number byte count passed its limit")
    `ASSERT_CLK(a_body_has_length,
        (state_reg.phase == PH_MBODY || state_reg.phase == PH_SXBODY
         || state_reg.phase == PH_SKIP || state_reg.phase == PH_MVALUE)
        |-> state_reg.bytes_left != 28'd0,
        "payload phase entered with nothing left to read")

endmodule

`default_nettype wire

// File: rtl/midi_track_event_parser_unit.sv
// Top level of the track event parser: input register, parser, result register.
// Depends on mtep_pkg, mtep_parser and assert_macros.svh.
//
//  channel   direction  handshake                   payload
//  item      in         item_valid / item_stall     mtep_pkg::item_t   (one track byte)
//  result    out        result_valid / result_stall mtep_pkg::result_t (zero or one per byte)
//
// One byte a cycle while results are not stalled: a byte waits in the input register, is
// decoded by the parser and its result, if any, lands in the result register.
// rst_n clears the parser state and both valid flags asynchronously.
// A stalled result holds the parser and the input register; the input register takes
// a new byte in the same cycle in which the one it holds moves on.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module midi_track_event_parser_unit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire mtep_pkg::item_t   item,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output mtep_pkg::result_t      result
);
    import mtep_pkg::*;

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_result_reg;
    logic    advance;
    logic    res_valid;
    result_t res;

    // Decode the held byte when the result register is free or being emptied.
    assign advance    = in_valid_reg && (!out_valid_reg || !result_stall);
    assign item_stall = in_valid_reg && !advance;

    mtep_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .item      (in_item_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!item_stall)
                in_valid_reg <= item_valid;
            if (advance)
                out_valid_reg <= res_valid;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!item_stall && item_valid)
            in_item_reg <= item;
        if (advance && res_valid)
            out_result_reg <= res;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_result_reg;

    `ASSERT_CLK(a_stall_needs_byte, item_stall |-> in_valid_reg,
        "input stalled with an empty input register")
    `ASSERT_CLK(a_empty_is_last, result_valid && !result.payload_valid |-> result.is_last,
        "result without payload does not close its event")
    `ASSERT_CLK(a_error_is_last, result_valid && result.error_code != ERR_NONE
        |-> result.is_last && !result.payload_valid,
        "flagged result does not close its event")
    `ASSERT_CLK(a_voice_fields, result_valid && result.event_kind > KIND_BEND
        |-> result.channel == 4'h0 && !result.restated_status,
        "channel fields set on a non-voice result")

endmodule

`default_nettype wire

// File: test/track_event_checker.sv
// Checker for the track event parser: watches both channels, predicts each result
// from the accepted bytes and compares it field by field with what the block delivers.
// Depends on mtep_pkg for the transaction structs, event kinds and error codes.
`timescale 1ns / 1ps

module track_event_checker
    import mtep_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    input  logic    item_stall,
    input  item_t   item,
    input  logic    result_valid,
    input  logic    result_stall,
    input  result_t result,
    output int      errors,
    output int      outstanding
);

    typedef enum logic [3:0] {
        AT_DELTA,
        AT_STATUS,
        AT_DATA1,
        AT_DATA2,
        AT_META_TYPE,
        AT_META_LEN,
        AT_META_BODY,
        AT_META_VALUE,
        AT_SKIP,
        AT_SYSEX_LEN,
        AT_SYSEX_BODY
    } parse_phase_t;

    typedef enum logic [1:0] {MC_VALUE, MC_FIXED, MC_FREE, MC_UNKNOWN} meta_class_t;
    typedef enum logic [1:0] {VLQ_MORE, VLQ_DONE, VLQ_OVERLONG} vlq_t;

    parse_phase_t pstate;
    logic [7:0]   run_status;
    logic [7:0]   status_now;
    logic         restated;
    logic [27:0]  delta_ticks;
    logic [2:0]   vlq_bytes;
    logic [27:0]  remaining;
    logic [7:0]   meta_code;
    logic [23:0]  meta_acc;
    logic [7:0]   held_data;

    result_t expected_events[$];
    result_t want;

    function automatic meta_class_t classify_meta(input logic [7:0] t);
        if (t == 8'h00 || t == 8'h20 || t == 8'h21 || t == 8'h51)
            return MC_VALUE;
        if ((t >= 8'h01 && t <= 8'h09) || t == 8'h7F)
            return MC_FREE;
        if (t == 8'h2F || t == 8'h54 || t == 8'h58 || t == 8'h59)
            return MC_FIXED;
        return MC_UNKNOWN;
    endfunction

    // Length that a fixed or valued meta kind must carry.
    function automatic logic [27:0] meta_length(input logic [7:0] t);
        case (t)
            8'h00:        return 28'd2;
            8'h20, 8'h21: return 28'd1;
            8'h51:        return 28'd3;
            8'h54:        return 28'd5;
            8'h58:        return 28'd4;
            8'h59:        return 28'd2;
            default:      return 28'd0;
        endcase
    endfunction

    function automatic result_t make_result(input kind_t kind, input logic [7:0] pa,
                                            input logic [7:0] pb, input logic [23:0] mval,
                                            input logic [7:0] pbyte, input logic pvalid,
                                            input logic last, input err_t err);
        result_t r;
        logic    chan;
        chan = (kind <= KIND_BEND);
        r = '0;
        r.event_delta     = delta_ticks;
        r.event_kind      = kind;
        r.channel         = chan ? status_now[3:0] : 4'd0;
        r.param_a         = pa;
        r.param_b         = pb;
        r.restated_status = chan ? restated : 1'b0;
        r.meta_type       = (kind == KIND_META) ? meta_code : 8'd0;
        r.meta_value      = mval;
        r.payload_byte    = pbyte;
        r.payload_valid   = pvalid;
        r.is_last         = last;
        r.error_code      = err;
        return r;
    endfunction

    // Append a predicted result at the tail of the queue.
    task automatic queue_expected(input result_t r);
        expected_events.insert(expected_events.size(), r);
    endtask

    task automatic clear_parser();
        pstate      = AT_DELTA;
        run_status  = '0;
        status_now  = '0;
        restated    = 1'b0;
        delta_ticks = '0;
        vlq_bytes   = '0;
        remaining   = '0;
        meta_code   = '0;
        meta_acc    = '0;
        held_data   = '0;
    endtask

    task automatic end_event();
        pstate      = AT_DELTA;
        delta_ticks = '0;
        vlq_bytes   = '0;
        remaining   = '0;
    endtask

    task automatic take_vlq(inout logic [27:0] acc, input logic [7:0] b, output vlq_t res);
        if (acc[27:21] != 0)
            res = VLQ_OVERLONG;
        else
        begin
            acc = {acc[20:0], b[6:0]};
            vlq_bytes = vlq_bytes + 3'd1;
            if (b[7])
                res = (vlq_bytes >= VLQ_MAX_BYTES) ? VLQ_OVERLONG : VLQ_MORE;
            else
                res = VLQ_DONE;
        end
    endtask

    task automatic take_first_data(input logic [7:0] b);
        kind_t k;
        k = status_now[7:4] - 4'd8;
        held_data = b;
        if (status_now[7:4] == 4'hC || status_now[7:4] == 4'hD)
        begin
            queue_expected(make_result(k, b, 0, 0, 0, 0, 1, ERR_NONE));
            end_event();
        end
        else
            pstate = AT_DATA2;
    endtask

    task automatic parse_byte(input item_t it);
        logic [7:0]  b;
        vlq_t        vr;
        meta_class_t cls;
        kind_t       k;
        err_t        err;
        b = it.data_byte;
        if (it.track_start)
            clear_parser();
        case (pstate)
            AT_STATUS:
            begin
                if (b < 8'h80)
                begin
                    if (run_status == 0)
                    begin
                        queue_expected(
                            make_result(KIND_NONE, 0, 0, 0, 0, 0, 1, ERR_NO_RUNNING));
                        end_event();
                    end
                    else
                    begin
                        status_now = run_status;
                        restated   = 1'b0;
                        take_first_data(b);
                    end
                end
                else
                begin
                    restated   = (run_status == b);
                    status_now = b;
                    vlq_bytes  = '0;
                    remaining  = '0;
                    if (b < STATUS_SYSEX)
                    begin
                        run_status = b;
                        pstate     = AT_DATA1;
                    end
                    else if (b == STATUS_META)
                        pstate = AT_META_TYPE;
                    else
                        pstate = AT_SYSEX_LEN;
                end
            end
            AT_DATA1:
                take_first_data(b);
            AT_DATA2:
            begin
                k = status_now[7:4] - 4'd8;
                queue_expected(make_result(k, held_data, b, 0, 0, 0, 1, ERR_NONE));
                end_event();
            end
            AT_META_TYPE:
            begin
                meta_code = b;
                vlq_bytes = '0;
                remaining = '0;
                pstate    = AT_META_LEN;
            end
            AT_META_LEN:
            begin
                take_vlq(remaining, b, vr);
                if (vr == VLQ_OVERLONG)
                begin
                    queue_expected(
                        make_result(KIND_META, 0, 0, 0, 0, 0, 1, ERR_OVERLONG));
                    end_event();
                end
                else if (vr == VLQ_DONE)
                begin
                    vlq_bytes = '0;
                    cls = classify_meta(meta_code);
                    if (cls == MC_UNKNOWN ||
                        (cls != MC_FREE && remaining != meta_length(meta_code)))
                    begin
                        err = (cls == MC_UNKNOWN) ? ERR_META_TYPE : ERR_META_LEN;
                        if (remaining == 0)
                        begin
                            queue_expected(
                                make_result(KIND_META, 0, 0, 0, 0, 0, 1, err));
                            end_event();
                        end
                        else
                            pstate = AT_SKIP;
                    end
                    else if (remaining == 0)
                    begin
                        queue_expected(
                            make_result(KIND_META, 0, 0, 0, 0, 0, 1, ERR_NONE));
                        end_event();
                    end
                    else
                    begin
                        meta_acc = '0;
                        pstate   = (cls == MC_VALUE) ? AT_META_VALUE : AT_META_BODY;
                    end
                end
            end
            AT_META_VALUE:
            begin
                meta_acc  = {meta_acc[15:0], b};
                remaining = remaining - 28'd1;
                if (remaining == 0)
                begin
                    queue_expected(
                        make_result(KIND_META, 0, 0, meta_acc, 0, 0, 1, ERR_NONE));
                    end_event();
                end
            end
            AT_META_BODY, AT_SYSEX_BODY:
            begin
                k = (pstate == AT_META_BODY) ? KIND_META : KIND_SYSEX;
                remaining = remaining - 28'd1;
                queue_expected(
                    make_result(k, 0, 0, 0, b, 1, remaining == 0, ERR_NONE));
                if (remaining == 0)
                    end_event();
            end
            AT_SKIP:
            begin
                remaining = remaining - 28'd1;
                if (remaining == 0)
                begin
                    err = (classify_meta(meta_code) == MC_UNKNOWN) ? ERR_META_TYPE
                                                                    : ERR_META_LEN;
                    queue_expected(make_result(KIND_META, 0, 0, 0, 0, 0, 1, err));
                    end_event();
                end
            end
            AT_SYSEX_LEN:
            begin
                take_vlq(remaining, b, vr);
                if (vr == VLQ_OVERLONG)
                begin
                    queue_expected(
                        make_result(KIND_SYSEX, 0, 0, 0, 0, 0, 1, ERR_OVERLONG));
                    end_event();
                end
                else if (vr == VLQ_DONE)
                begin
                    vlq_bytes = '0;
                    if (status_now == STATUS_SYSEX)
                    begin
                        // Prepend the F0 byte that the file format strips.
                        queue_expected(make_result(KIND_SYSEX, 0, 0, 0,
                            STATUS_SYSEX, 1, remaining == 0, ERR_NONE));
                        if (remaining == 0)
                            end_event();
                        else
                            pstate = AT_SYSEX_BODY;
                    end
                    else if (remaining == 0)
                    begin
                        queue_expected(
                            make_result(KIND_SYSEX, 0, 0, 0, 0, 0, 1, ERR_NONE));
                        end_event();
                    end
                    else
                        pstate = AT_SYSEX_BODY;
                end
            end
            default:
            begin
                take_vlq(delta_ticks, b, vr);
                if (vr == VLQ_OVERLONG)
                begin
                    queue_expected(
                        make_result(KIND_NONE, 0, 0, 0, 0, 0, 1, ERR_OVERLONG));
                    end_event();
                end
                else if (vr == VLQ_DONE)
                begin
                    vlq_bytes = '0;
                    pstate    = AT_STATUS;
                end
                else
                    pstate = AT_DELTA;
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (got_v !== exp_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parser();
            expected_events.delete();
            errors      = 0;
            outstanding = 0;
        end
        else
        begin
            if (item_valid && !item_stall)
                parse_byte(item);
            if (result_valid && !result_stall)
            begin
                if (expected_events.size() == 0)
                begin
                    $error("result transaction with none expected: 0x%0h", result);
                    errors++;
                end
                else
                begin
                    want = expected_events.pop_front();
                    check_field("event_delta", want.event_delta, result.event_delta);
                    check_field("event_kind", want.event_kind, result.event_kind);
                    check_field("channel", want.channel, result.channel);
                    check_field("param_a", want.param_a, result.param_a);
                    check_field("param_b", want.param_b, result.param_b);
                    check_field("restated_status", want.restated_status,
                                result.restated_status);
                    check_field("meta_type", want.meta_type, result.meta_type);
                    check_field("meta_value", want.meta_value, result.meta_value);
                    check_field("payload_byte", want.payload_byte, result.payload_byte);
                    check_field("payload_valid", want.payload_valid, result.payload_valid);
                    check_field("is_last", want.is_last, result.is_last);
                    check_field("error_code", want.error_code, result.error_code);
                end
            end
            outstanding = expected_events.size();
        end
    end

endmodule

// File: test/tb.sv
// Top of the track event parser testbench: clock, reset, byte stream stimulus,
// random idling on both channels and the final verdict.
// Depends on mtep_pkg, midi_track_event_parser_unit and track_event_checker.
`timescale 1ns / 1ps

module tb;
    import mtep_pkg::*;

    localparam int BYTE_TARGET  = 550;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 2000;
    localparam int SEGMENT_SIZE = 40;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    item_t   item         = '0;
    logic    result_stall = 1'b0;
    logic    item_stall;
    logic    result_valid;
    result_t result;

    int mismatches;
    int outstanding;

    item_t      byte_stream[$];
    logic       fresh_track = 1'b0;
    logic [7:0] gen_running = '0;
    int         tx_max_gap  = 3;
    logic       rx_burst    = 1'b0;
    logic       long_hold   = 1'b0;
    int         quiet_cycles = 0;

    always #4 clk = ~clk;

    midi_track_event_parser_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    track_event_checker scoreboard (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .errors       (mismatches),
        .outstanding  (outstanding)
    );

    task automatic push_byte(input logic [7:0] b);
        item_t it;
        it.data_byte   = b;
        it.track_start = fresh_track;
        byte_stream.insert(byte_stream.size(), it);
        fresh_track = 1'b0;
    endtask

    // Encode a number as a variable-length quantity, optionally padded with 0x80 bytes.
    task automatic push_vlq(input logic [27:0] v, input int pad);
        int          n;
        logic [27:0] part;
        n = 1;
        while (n < 4 && (v >> (7 * n)) != 0)
            n++;
        n = n + pad;
        if (n > 4)
            n = 4;
        for (int i = n - 1; i >= 0; i--)
        begin
            part = v >> (7 * i);
            push_byte({i > 0, part[6:0]});
        end
    endtask

    function automatic int draw_pad();
        return ($urandom_range(0, 4) == 0) ? int'($urandom_range(1, 3)) : 0;
    endfunction

    task automatic push_random_bytes(input int count);
        repeat (count)
            push_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic gen_delta();
        logic [27:0] v;
        case ($urandom_range(0, 9))
            6, 7:    v = 28'($urandom_range(128, 16383));
            8:       v = 28'($urandom_range(0, 28'hFFFFFFF));
            9:       v = $urandom_range(0, 1) ? 28'hFFFFFFF : 28'h0;
            default: v = 28'($urandom_range(0, 127));
        endcase
        push_vlq(v, draw_pad());
    endtask

    task automatic gen_channel();
        logic [7:0] st;
        logic       omit;
        st   = 8'($urandom_range(8'h80, 8'hEF));
        omit = 1'b0;
        if (gen_running != 0)
        begin
            case ($urandom_range(0, 3))
                0, 1:
                begin
                    st   = gen_running;
                    omit = 1'b1;
                end
                2:       st = gen_running;
                default: ;
            endcase
        end
        if (!omit)
            push_byte(st);
        gen_running = st;
        push_byte(omit ? 8'($urandom_range(0, 127)) : 8'($urandom_range(0, 255)));
        if (st[7:4] != 4'hC && st[7:4] != 4'hD)
            push_byte(8'($urandom_range(0, 255)));
    endtask

    function automatic int draw_free_len();
        return ($urandom_range(0, 39) == 0) ? int'($urandom_range(128, 140))
                                            : int'($urandom_range(0, 6));
    endfunction

    task automatic gen_meta();
        logic [7:0] t;
        int         len;
        case ($urandom_range(0, 11))
            0:
            begin
                t = 8'h00;
                len = 2;
            end
            1:
            begin
                t = 8'($urandom_range(1, 9));
                len = draw_free_len();
            end
            2:
            begin
                t = 8'h20;
                len = 1;
            end
            3:
            begin
                t = 8'h21;
                len = 1;
            end
            4:
            begin
                t = 8'h2F;
                len = 0;
            end
            5:
            begin
                t = 8'h51;
                len = 3;
            end
            6:
            begin
                t = 8'h54;
                len = 5;
            end
            7:
            begin
                t = 8'h58;
                len = 4;
            end
            8:
            begin
                t = 8'h59;
                len = 2;
            end
            9:
            begin
                t = 8'h7F;
                len = draw_free_len();
            end
            default:
            begin
                t = 8'($urandom_range(0, 255));
                len = $urandom_range(0, 4);
            end
        endcase
        // Break the length now and then to reach the skip path.
        if ($urandom_range(0, 7) == 0)
            len = $urandom_range(0, 6);
        push_byte(STATUS_META);
        push_byte(t);
        push_vlq(28'(len), draw_pad());
        push_random_bytes(len);
    endtask

    task automatic gen_sysex();
        int len;
        push_byte($urandom_range(0, 1) ? STATUS_SYSEX : 8'($urandom_range(8'hF1, 8'hFE)));
        len = draw_free_len();
        push_vlq(28'(len), draw_pad());
        push_random_bytes(len);
    endtask

    task automatic gen_broken();
        case ($urandom_range(0, 4))
            0:
            begin
                // Data byte straight after the delta of a fresh track.
                fresh_track = 1'b1;
                gen_running = '0;
                push_vlq(28'($urandom_range(0, 127)), 0);
                push_byte(8'($urandom_range(0, 127)));
            end
            1:
                repeat (4)
                    push_byte(8'h80 | 8'($urandom_range(0, 127)));
            2:
            begin
                gen_delta();
                push_byte(STATUS_META);
                push_byte(8'($urandom_range(0, 255)));
                repeat (4)
                    push_byte(8'h80 | 8'($urandom_range(0, 127)));
            end
            3:
            begin
                gen_delta();
                push_byte($urandom_range(0, 1) ? STATUS_SYSEX : 8'($urandom_range(8'hF1, 8'hFE)));
                repeat (4)
                    push_byte(8'h80 | 8'($urandom_range(0, 127)));
            end
            default:
            begin
                // Garbage, then resync with a new track.
                push_random_bytes($urandom_range(1, 6));
                fresh_track = 1'b1;
                gen_running = '0;
            end
        endcase
    endtask

    task automatic gen_event();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            fresh_track = 1'b1;
            gen_running = '0;
        end
        if (r < 12)
            gen_broken();
        else
        begin
            gen_delta();
            if (r < 60)
                gen_channel();
            else if (r < 85)
                gen_meta();
            else
                gen_sysex();
        end
    endtask

    // Entered and left at a falling edge; valid stays high after the transaction.
    task automatic send_stream();
        int    gap;
        item_t it;
        while (byte_stream.size() != 0)
        begin
            it  = byte_stream.pop_front();
            gap = (tx_max_gap == 0) ? 0 : $urandom_range(0, tx_max_gap);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap)
                    @(negedge clk);
            end
            item_valid <= 1'b1;
            item       <= it;
            do
                @(posedge clk);
            while (item_stall);
            @(negedge clk);
        end
    endtask

    task automatic drain_results();
        item_valid <= 1'b0;
        wait (outstanding == 0);
        @(negedge clk);
    endtask

    initial
    begin : result_side
        int n;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (long_hold)
            begin
                n = HOLD_CYCLES;
                long_hold = 1'b0;
            end
            else
                n = rx_burst ? 0 : $urandom_range(0, 16);
            if (n > 0)
            begin
                result_stall <= 1'b1;
                repeat (n)
                    @(negedge clk);
            end
            result_stall <= 1'b0;
            do
                @(posedge clk);
            while (!result_valid);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : byte_side
        int sent;
        int seg;
        sent = 0;
        seg  = 0;
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: no running status, largest delta on channel 15, running status,
        // restated status, overlong delta, empty F0 sysex, end of track.
        fresh_track = 1'b1;
        push_byte(8'h00);
        push_byte(8'h05);
        push_vlq(28'hFFFFFFF, 0);
        push_byte(8'h8F);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(8'h7F);
        push_byte(8'h80);
        push_byte(8'h00);
        push_byte(8'h8F);
        push_byte(8'h01);
        push_byte(8'h02);
        push_byte(8'h81);
        push_byte(8'h80);
        push_byte(8'h80);
        push_byte(8'h80);
        push_byte(8'h00);
        push_byte(STATUS_SYSEX);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(STATUS_META);
        push_byte(8'h2F);
        push_byte(8'h00);
        sent = byte_stream.size();
        gen_running = 8'h8F;
        send_stream();
        drain_results();

        fresh_track = 1'b1;
        gen_running = '0;
        while (sent < BYTE_TARGET)
        begin
            case ($urandom_range(0, 2))
                0:       tx_max_gap = 0;
                1:       tx_max_gap = 3;
                default: tx_max_gap = 16;
            endcase
            rx_burst = ($urandom_range(0, 3) == 0);
            // Hold results back while bytes keep coming so the block backs up.
            if (seg == 4 || seg == 10)
            begin
                tx_max_gap = 0;
                rx_burst   = 1'b0;
                long_hold  = 1'b1;
            end
            while (byte_stream.size() < SEGMENT_SIZE)
                gen_event();
            sent += byte_stream.size();
            send_stream();
            if (seg == 7)
                drain_results();
            seg++;
        end

        item_valid <= 1'b0;
        wait (outstanding == 0);
        repeat (10)
            @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
